[hw/rtl/megd_pkg.sv]
// Shared types and constants for the modem escape guard detector.
// No dependencies; imported by megd_lane and modem_escape_guard_detector.
`default_nettype none

package megd_pkg;

    localparam int TICK_W  = 13;
    localparam int LEN_W   = 3;
    localparam int SLOT_W  = 2;
    localparam int CNT_W   = 3;
    localparam int SEQ_LEN = 3;

    typedef logic [7:0]        t_byte;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [TICK_W-1:0] t_tick;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [1:0]        t_mark;

    localparam t_tick TICK_MAX = {TICK_W{1'b1}};
    localparam t_cnt  CNT_SAT  = 3'd4;

    // Gap mark codes
    localparam t_mark MARK_UNSET = 2'd0;
    localparam t_mark MARK_LONG  = 2'd1;
    localparam t_mark MARK_SHORT = 2'd2;

    // Item kinds
    localparam logic KIND_MSG  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Configuration register indexes
    localparam logic CFG_ESCAPE_CHAR = 1'b0;
    localparam logic CFG_GUARD_UNITS = 1'b1;

    localparam t_byte ESCAPE_CHAR_RST = 8'd43;
    localparam t_byte GUARD_UNITS_RST = 8'd50;

endpackage

`default_nettype wire

[hw/rtl/megd_lane.sv]
// One byte lane of the escape guard detector: flags a used byte that is not
// the escape character. Depends on megd_pkg.
`default_nettype none

module megd_lane #(
    parameter int LANE = 0
) (
    input  megd_pkg::t_byte i_byte,
    input  megd_pkg::t_byte i_escape_char,
    input  megd_pkg::t_len  i_msg_length,
    output logic            o_mismatch
);
    import megd_pkg::*;

    logic w_used;

    // Byte is carried only when the length reaches past this lane
    assign w_used     = (i_msg_length > LEN_W'(LANE));
    assign o_mismatch = w_used && (i_byte != i_escape_char);

endmodule

`default_nettype wire

[hw/rtl/modem_escape_guard_detector.sv]
// Top level of the modem escape guard detector: byte lanes, merge of the lane
// results, detector state and output register. Depends on megd_pkg, megd_lane.
//
// Usage:
//   Input channel (i_valid / o_ready) carries either a message (i_kind = 0,
//   up to three bytes plus a length, length 4 meaning more than three) or a
//   one-millisecond tick (i_kind = 1). Every transfer yields exactly one
//   result on the output channel (o_valid / i_ready): o_scan_status is 1 for
//   a message that completes long-short-short escape spacing and starts the
//   guard timer; o_escape_detected is 1 for the tick on which it expires.
//   The result appears in the output register on the cycle after the input
//   transfer. Throughput is one item per cycle while the receiver takes each
//   result; the whole state update for an item is one register stage fed by
//   three parallel byte-compare lanes and a merge of their flags.
//   While a result is held, a new item is still accepted in the same cycle
//   the held one is taken; if the receiver stalls, o_ready drops and the
//   held result stays unchanged.
//   Configuration (i_cfg_valid / o_cfg_ready, always ready) writes index 0
//   (escape character) or index 1 (guard time in TICKS_PER_UNIT ticks); write
//   only while the block is idle.
//   Synchronous active-low reset restores escape character '+', guard 50,
//   elapsed time saturated, ring unset, count zero and the timer stopped.
`default_nettype none

module modem_escape_guard_detector #(
    parameter int TICKS_PER_UNIT = 20
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    // input item channel
    input  wire             i_valid,
    output logic            o_ready,
    input  wire             i_kind,
    input  megd_pkg::t_len  i_msg_length,
    input  megd_pkg::t_byte i_byte_first,
    input  megd_pkg::t_byte i_byte_second,
    input  megd_pkg::t_byte i_byte_third,
    // result channel
    output logic            o_valid,
    input  wire             i_ready,
    output logic            o_scan_status,
    output logic            o_escape_detected,
    // configuration write channel
    input  wire             i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire             i_cfg_index,
    input  megd_pkg::t_byte i_cfg_data
);
    import megd_pkg::*;

    // Full guard product width, and the width used for comparisons
    localparam int GUARD_W = $clog2(255 * TICKS_PER_UNIT + 1);
    localparam int CMP_W   = (GUARD_W > TICK_W) ? GUARD_W : TICK_W;

    // Configuration registers
    t_byte r_escape_char;
    t_byte r_guard_units;

    // Detector state
    t_tick r_elapsed,   n_elapsed;
    t_mark r_marks [SEQ_LEN];
    t_mark n_marks [SEQ_LEN];
    t_slot r_newest,    n_newest;
    t_cnt  r_count,     n_count;
    logic  r_timer_on,  n_timer_on;
    t_tick r_remaining, n_remaining;

    // Output register
    logic  r_out_valid;
    logic  r_scan_status, n_scan_status;
    logic  r_detected,    n_detected;

    logic               w_in_xfer;
    logic               w_cfg_xfer;
    logic [CMP_W-1:0]   w_guard;
    logic [CMP_W-1:0]   w_elapsed_ext;
    t_tick              w_timer_load;
    logic               w_first_short;
    t_byte              w_bytes    [SEQ_LEN];
    logic [SEQ_LEN-1:0] w_mismatch;
    logic               w_len_ok;
    logic [2:0]         w_slot_off [SEQ_LEN];
    t_mark              w_new_marks [SEQ_LEN];
    logic               w_slot_wr  [SEQ_LEN];
    logic [2:0]         w_slot_sum;
    t_slot              w_new_newest;
    logic [2:0]         w_cnt_sum;
    t_cnt               w_new_count;
    logic               w_spacing_ok;
    t_mark              w_newest_mark;
    t_mark              w_expect;

    // ---------------------------------------------------------------------
    // Handshakes: output register frees up when taken, so accept alongside
    // ---------------------------------------------------------------------
    assign o_ready     = !r_out_valid || i_ready;
    assign w_in_xfer   = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_xfer  = i_cfg_valid;

    assign o_valid           = r_out_valid;
    assign o_scan_status     = r_scan_status;
    assign o_escape_detected = r_detected;

    // ---------------------------------------------------------------------
    // Guard time: narrow multiply by a constant, timer load saturates
    // ---------------------------------------------------------------------
    assign w_guard       = CMP_W'(r_guard_units) * CMP_W'(TICKS_PER_UNIT);
    assign w_elapsed_ext = CMP_W'(r_elapsed);
    assign w_first_short = (w_elapsed_ext < w_guard);
    assign w_timer_load  = (w_guard > CMP_W'(TICK_MAX)) ? TICK_MAX : w_guard[TICK_W-1:0];

    // ---------------------------------------------------------------------
    // Byte lanes: one comparator per message byte
    // ---------------------------------------------------------------------
    assign w_bytes[0] = i_byte_first;
    assign w_bytes[1] = i_byte_second;
    assign w_bytes[2] = i_byte_third;

    for (genvar l = 0; l < SEQ_LEN; l++) begin : g_lane
        megd_lane #(
            .LANE (l)
        ) u_lane (
            .i_byte        (w_bytes[l]),
            .i_escape_char (r_escape_char),
            .i_msg_length  (i_msg_length),
            .o_mismatch    (w_mismatch[l])
        );
    end

    assign w_len_ok = (i_msg_length != '0) && (i_msg_length <= LEN_W'(SEQ_LEN));

    // ---------------------------------------------------------------------
    // Merge: ring slots written by this message. Slot k takes the write
    // whose position is (k - newest - 1) mod 3; only the first byte can be
    // long, and only if the guard silence has passed.
    // ---------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < SEQ_LEN; k++) begin
            w_slot_off[k] = 3'(k) + 3'd2 - {1'b0, r_newest};
            if (w_slot_off[k] >= 3'(SEQ_LEN)) begin
                w_slot_off[k] = w_slot_off[k] - 3'(SEQ_LEN);
            end
            w_slot_wr[k]   = (w_slot_off[k] < i_msg_length);
            w_new_marks[k] = w_slot_wr[k] ?
                             (((w_slot_off[k] == 3'd0) && !w_first_short) ? MARK_LONG
                                                                           : MARK_SHORT)
                             : r_marks[k];
        end
    end

    // Advance the newest slot by the length, wrap modulo three
    assign w_slot_sum   = {1'b0, r_newest} + i_msg_length;
    assign w_new_newest = (w_slot_sum >= 3'(SEQ_LEN)) ? SLOT_W'(w_slot_sum - 3'(SEQ_LEN))
                                                       : SLOT_W'(w_slot_sum);

    // Count saturates at four
    assign w_cnt_sum   = r_count + i_msg_length;
    assign w_new_count = (w_cnt_sum > CNT_SAT) ? CNT_SAT : w_cnt_sum;

    // Spacing check on the updated ring: newest short, then long, then short
    always_comb begin
        case (w_new_newest)
            2'd0: begin
                w_spacing_ok  = (w_new_marks[0] == MARK_SHORT) &&
                                (w_new_marks[1] == MARK_LONG) &&
                                (w_new_marks[2] == MARK_SHORT);
                w_newest_mark = w_new_marks[0];
            end
            2'd1: begin
                w_spacing_ok  = (w_new_marks[1] == MARK_SHORT) &&
                                (w_new_marks[2] == MARK_LONG) &&
                                (w_new_marks[0] == MARK_SHORT);
                w_newest_mark = w_new_marks[1];
            end
            2'd2: begin
                w_spacing_ok  = (w_new_marks[2] == MARK_SHORT) &&
                                (w_new_marks[0] == MARK_LONG) &&
                                (w_new_marks[1] == MARK_SHORT);
                w_newest_mark = w_new_marks[2];
            end
            default: begin
                w_spacing_ok  = 1'b0;
                w_newest_mark = MARK_UNSET;
            end
        endcase
    end

    // Partial sequence: slot one must hold the long mark, others short
    assign w_expect = (w_new_newest == 2'd1) ? MARK_LONG : MARK_SHORT;

    // ---------------------------------------------------------------------
    // Next state for one accepted item
    // ---------------------------------------------------------------------
    always_comb begin
        n_elapsed     = r_elapsed;
        n_marks       = r_marks;
        n_newest      = r_newest;
        n_count       = r_count;
        n_timer_on    = r_timer_on;
        n_remaining   = r_remaining;
        n_scan_status = 1'b0;
        n_detected    = 1'b0;

        if (i_kind == KIND_TICK) begin
            if (r_elapsed != TICK_MAX) begin
                n_elapsed = r_elapsed + 1'b1;
            end
            if (r_timer_on) begin
                if (r_remaining <= TICK_W'(1)) begin
                    // expiry: raise the indication, keep the ring position
                    n_timer_on  = 1'b0;
                    n_remaining = '0;
                    n_count     = '0;
                    n_detected  = 1'b1;
                end else begin
                    n_remaining = r_remaining - 1'b1;
                end
            end
        end else if (r_timer_on) begin
            // any message cancels a running guard timer
            n_timer_on  = 1'b0;
            n_remaining = '0;
            n_count     = '0;
            n_newest    = '0;
            n_elapsed   = '0;
        end else if (!w_len_ok || (|w_mismatch)) begin
            n_count   = '0;
            n_newest  = '0;
            n_elapsed = '0;
        end else begin
            n_marks   = w_new_marks;
            n_newest  = w_new_newest;
            n_count   = w_new_count;
            n_elapsed = '0;
            if (w_new_count == 3'(SEQ_LEN)) begin
                if (w_spacing_ok) begin
                    // sequence complete: start the guard timer, hold elapsed
                    n_timer_on    = 1'b1;
                    n_remaining   = w_timer_load;
                    n_scan_status = 1'b1;
                    n_elapsed     = r_elapsed;
                end else begin
                    n_count  = '0;
                    n_newest = '0;
                end
            end else if ((w_new_count == 3'd1) || (w_new_count == 3'd2)) begin
                if (w_newest_mark != w_expect) begin
                    n_count  = '0;
                    n_newest = '0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_char <= ESCAPE_CHAR_RST;
            r_guard_units <= GUARD_UNITS_RST;
        end else if (w_cfg_xfer) begin
            unique case (i_cfg_index)
                CFG_ESCAPE_CHAR: r_escape_char <= i_cfg_data;
                CFG_GUARD_UNITS: r_guard_units <= i_cfg_data;
                default:         r_escape_char <= r_escape_char;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed   <= TICK_MAX;
            r_marks     <= '{default: MARK_UNSET};
            r_newest    <= '0;
            r_count     <= '0;
            r_timer_on  <= 1'b0;
            r_remaining <= '0;
        end else if (w_in_xfer) begin
            r_elapsed   <= n_elapsed;
            r_marks     <= n_marks;
            r_newest    <= n_newest;
            r_count     <= n_count;
            r_timer_on  <= n_timer_on;
            r_remaining <= n_remaining;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload loads on every input transfer; no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_scan_status <= n_scan_status;
            r_detected    <= n_detected;
        end
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_timer_needs_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_timer_on |-> (r_count == 3'(SEQ_LEN)))
        else $error("guard timer running without three escape characters");

    a_status_starts_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_scan_status) |-> r_timer_on)
        else $error("sequence reported but guard timer not running");

    a_detect_stops_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_detected) |-> (!r_timer_on && (r_count == '0)))
        else $error("escape reported but timer or count not cleared");

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_scan_status && r_detected))
        else $error("status and escape indication raised together");

    a_ring_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_newest != 2'd3) && (r_count <= CNT_SAT))
        else $error("ring slot or escape count out of range");

endmodule

`default_nettype wire
